// ----- hw/rtl/bbia_pkg.sv -----
// Package for the bitmap block/inode allocator: item types, codes and control structs.
`default_nettype none

package bbia_pkg;

	localparam int BLOCK_COUNT_DEF = 128;
	localparam int INODE_COUNT_DEF = 64;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic POOL_BLOCK = 1'b0;
	localparam logic POOL_INODE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic       kind;
		logic       pool;
		logic [7:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [7:0] result_index;
		logic [1:0] status;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic advance;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bitmap_block_inode_allocator_unit.sv -----
// Top level of the first-fit bitmap allocator for data blocks and inodes.
//
// Request channel (req_valid/req_ready/req): kind, pool, entry_index. An item is
// taken when req_valid and req_ready are high at a clock edge; req_ready is high
// only while no request is in progress. Response channel (rsp_valid/rsp_ready/rsp):
// result_index and status, one response per request, in order.
// A free touches one bitmap byte. An allocate reads one bitmap byte per cycle
// from byte 0 until a byte with a free bit or the pool's last byte: up to
// BLOCK_COUNT/8 bytes for the block pool and INODE_COUNT/8 for the inode pool,
// rounded up. Either way the result is then committed to the output register,
// raising rsp_valid, and only after that is req_ready high again for the next
// request.
// The response sits in an output register, so a new request is accepted while a
// response waits. If the receiver stalls and a second response is ready, the
// controller holds it until the register frees, and accepts nothing meanwhile.
// Reset (arst_n low, asynchronous) loads the freshly formatted maps: blocks 0..9
// and inode 0 are taken, everything else is free; no response is pending.
`default_nettype none

module bitmap_block_inode_allocator_unit #(
	parameter int BLOCK_COUNT = bbia_pkg::BLOCK_COUNT_DEF,
	parameter int INODE_COUNT = bbia_pkg::INODE_COUNT_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  bbia_pkg::req_t    req,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output bbia_pkg::rsp_t    rsp
);

	bbia_pkg::cmd_t cmd;
	bbia_pkg::sts_t sts;

	bbia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bbia_datapath #(
		.BLOCK_COUNT (BLOCK_COUNT),
		.INODE_COUNT (INODE_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/bbia_ctrl.sv -----
// Controller state machine for the bitmap allocator: accept, scan, commit.
`default_nettype none

module bbia_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  bbia_pkg::sts_t    sts,
	output bbia_pkg::cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		cmd.commit  = 1'b0;
		req_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (!sts.done) begin
					cmd.advance = 1'b1;
				end else if (sts.out_free) begin
					// commit once the output register is free; hold here while the previous result is still unread
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bbia_datapath.sv -----
// Datapath for the bitmap allocator: both bitmaps, byte pointer, bit search, result register.
`default_nettype none

module bbia_datapath #(
	parameter int BLOCK_COUNT = bbia_pkg::BLOCK_COUNT_DEF,
	parameter int INODE_COUNT = bbia_pkg::INODE_COUNT_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  bbia_pkg::req_t    req,
	input  bbia_pkg::cmd_t    cmd,
	output bbia_pkg::sts_t    sts,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output bbia_pkg::rsp_t    rsp
);

	localparam int BLK_BYTES = (BLOCK_COUNT + 7) / 8;
	localparam int INO_BYTES = (INODE_COUNT + 7) / 8;
	localparam int MAX_BYTES = (BLK_BYTES > INO_BYTES) ? BLK_BYTES : INO_BYTES;
	localparam int PTR_W     = $clog2(MAX_BYTES);
	localparam int BLK_AW    = $clog2(BLK_BYTES);
	localparam int INO_AW    = (INO_BYTES > 1) ? $clog2(INO_BYTES) : 1;

	localparam logic [PTR_W-1:0] BLK_LAST = PTR_W'(BLK_BYTES - 1);
	localparam logic [PTR_W-1:0] INO_LAST = PTR_W'(INO_BYTES - 1);
	localparam logic [8:0]       BLK_CNT  = 9'(BLOCK_COUNT);
	localparam logic [8:0]       INO_CNT  = 9'(INODE_COUNT);

	bbia_pkg::req_t   req_q;
	bbia_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;
	logic [PTR_W-1:0] ptr_q;
	logic [7:0]       blk_map_q [BLK_BYTES];
	logic [7:0]       ino_map_q [INO_BYTES];

	logic [PTR_W-1:0]  byte_a;
	logic [BLK_AW-1:0] blk_a;
	logic [INO_AW-1:0] ino_a;
	logic [7:0]        rd_byte;
	logic [8:0]        count;
	logic [PTR_W-1:0]  last;
	logic [7:0]        avail;
	logic              found;
	logic [2:0]        fbit;
	logic              in_range;
	logic              wr_en;
	logic [7:0]        wr_byte;
	bbia_pkg::rsp_t    rsp_d;

	always_comb begin
		if (req_q.kind == bbia_pkg::KIND_FREE) begin
			byte_a = PTR_W'(req_q.entry_index[7:3]);
		end else begin
			byte_a = ptr_q;
		end
		blk_a = byte_a[BLK_AW-1:0];
		ino_a = byte_a[INO_AW-1:0];

		if (req_q.pool == bbia_pkg::POOL_INODE) begin
			rd_byte = ino_map_q[ino_a];
			count   = INO_CNT;
			last    = INO_LAST;
		end else begin
			rd_byte = blk_map_q[blk_a];
			count   = BLK_CNT;
			last    = BLK_LAST;
		end

		// a bit at or above the pool's count never counts as free
		for (int k = 0; k < 8; k++) begin
			avail[k] = !rd_byte[k] && (9'({ptr_q, 3'(k)}) < count);
		end
		found = |avail;
		fbit  = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (avail[k]) begin
				fbit = 3'(k);
			end
		end

		in_range = {1'b0, req_q.entry_index} < count;

		if (req_q.kind == bbia_pkg::KIND_FREE) begin
			sts.done = 1'b1;
			wr_en    = in_range;
			wr_byte  = rd_byte & ~(8'd1 << req_q.entry_index[2:0]);
			if (in_range) begin
				rsp_d.result_index = req_q.entry_index;
				rsp_d.status       = bbia_pkg::STATUS_OK;
			end else begin
				rsp_d.result_index = 8'd0;
				rsp_d.status       = bbia_pkg::STATUS_RANGE;
			end
		end else begin
			sts.done = found || (ptr_q == last);
			wr_en    = found;
			wr_byte  = rd_byte | (8'd1 << fbit);
			if (found) begin
				rsp_d.result_index = 8'({ptr_q, fbit});
				rsp_d.status       = bbia_pkg::STATUS_OK;
			end else begin
				rsp_d.result_index = 8'd0;
				rsp_d.status       = bbia_pkg::STATUS_FULL;
			end
		end

		sts.out_free = !rsp_valid_q || rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.advance) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	// freshly formatted layout: blocks 0..9 and inode 0 taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BLK_BYTES; i++) begin
				blk_map_q[i] <= (i == 0) ? 8'hFF : ((i == 1) ? 8'h03 : 8'h00);
			end
			for (int i = 0; i < INO_BYTES; i++) begin
				ino_map_q[i] <= (i == 0) ? 8'h01 : 8'h00;
			end
		end else if (cmd.commit && wr_en) begin
			if (req_q.pool == bbia_pkg::POOL_INODE) begin
				ino_map_q[ino_a] <= wr_byte;
			end else begin
				blk_map_q[blk_a] <= wr_byte;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- tb/bitmap_block_inode_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the block/inode bitmap allocator: directed and random requests.
module bitmap_block_inode_allocator_unit_tb;

	localparam int BLOCKS       = bbia_pkg::BLOCK_COUNT_DEF;
	localparam int INODES       = bbia_pkg::INODE_COUNT_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1630;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	bbia_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bbia_pkg::rsp_t rsp;

	// one bit per entry, set means taken; indexed by pool code
	logic [255:0]   pool_bits [0:1];
	bbia_pkg::rsp_t pending_rsps [$];
	bit             idle_en = 1'b1;
	int             n_err, cycles;
	int             n_alloc, n_full, n_free, n_range;

	bitmap_block_inode_allocator_unit #(
		.BLOCK_COUNT(BLOCKS),
		.INODE_COUNT(INODES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// first-fit over ascending index is the same order as byte then bit
	function automatic bbia_pkg::rsp_t next_response(input bbia_pkg::req_t r);
		bbia_pkg::rsp_t o;
		int             count;
		o     = '0;
		count = (r.pool == bbia_pkg::POOL_INODE) ? INODES : BLOCKS;
		if (r.kind == bbia_pkg::KIND_ALLOC) begin
			o.status = bbia_pkg::STATUS_FULL;
			for (int i = 0; i < count; i++) begin
				if (o.status == bbia_pkg::STATUS_FULL && !pool_bits[r.pool][i]) begin
					pool_bits[r.pool][i] = 1'b1;
					o.result_index       = 8'(i);
					o.status             = bbia_pkg::STATUS_OK;
				end
			end
			n_alloc++;
			if (o.status == bbia_pkg::STATUS_FULL)
				n_full++;
		end else begin
			n_free++;
			if (r.entry_index >= count) begin
				o.status = bbia_pkg::STATUS_RANGE;
				n_range++;
			end else begin
				pool_bits[r.pool][r.entry_index] = 1'b0;
				o.result_index = r.entry_index;
				o.status       = bbia_pkg::STATUS_OK;
			end
		end
		return o;
	endfunction

	task automatic send_item(input logic k, input logic p, input logic [7:0] idx);
		bbia_pkg::req_t r;
		r.kind        = k;
		r.pool        = p;
		r.entry_index = idx;
		if (idle_en)
			while ($urandom_range(99) < 25) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		pending_rsps.push_back(next_response(r));
	endtask

	task automatic flag_error(input string what, input bbia_pkg::rsp_t want,
		input bbia_pkg::rsp_t got);
		n_err++;
		if (n_err <= 10)
			$display("ERROR %s: expected index %0d status %0d, got index %0d status %0d",
				what, want.result_index, want.status, got.result_index, got.status);
	endtask

	always @(posedge clk)
		rsp_ready <= !idle_en || ($urandom_range(99) >= 25);

	always @(posedge clk) begin
		bbia_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				flag_error("unexpected response", '0, rsp);
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.result_index !== want.result_index || rsp.status !== want.status)
					flag_error("response mismatch", want, rsp);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses outstanding",
				cycles, pending_rsps.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// formatted layout: the first allocations land right after the reserved entries
	task automatic test_reset_layout();
		send_item(bbia_pkg::KIND_ALLOC, bbia_pkg::POOL_BLOCK, 8'h00);
		send_item(bbia_pkg::KIND_ALLOC, bbia_pkg::POOL_INODE, 8'h00);
		send_item(bbia_pkg::KIND_ALLOC, bbia_pkg::POOL_BLOCK, 8'hFF);	// index is don't-care
		send_item(bbia_pkg::KIND_ALLOC, bbia_pkg::POOL_INODE, 8'h80);
	endtask

	task automatic test_free_edges();
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_BLOCK, 8'd127);	// last, already free
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_BLOCK, 8'd128);	// first out of range
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_BLOCK, 8'd255);
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_INODE, 8'd63);
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_INODE, 8'd64);
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_INODE, 8'd255);
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_INODE, 8'd0);	// reserved inode
		send_item(bbia_pkg::KIND_ALLOC, bbia_pkg::POOL_INODE, 8'h55);
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_BLOCK, 8'd0);	// reserved block
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_BLOCK, 8'd0);	// freeing a free entry
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_BLOCK, 8'd9);
		send_item(bbia_pkg::KIND_ALLOC, bbia_pkg::POOL_BLOCK, 8'hAA);
		send_item(bbia_pkg::KIND_ALLOC, bbia_pkg::POOL_BLOCK, 8'h00);
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_INODE, 8'd5);
		send_item(bbia_pkg::KIND_FREE,  bbia_pkg::POOL_BLOCK, 8'd10);
		send_item(bbia_pkg::KIND_ALLOC, bbia_pkg::POOL_BLOCK, 8'h7F);
	endtask

	// bursts of alloc-heavy, balanced or free-heavy traffic so both pools swing between full and empty
	task automatic test_random(input int n);
		int         left, burst, alloc_pct, pool_mode, count;
		logic       k, p;
		logic [7:0] idx;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(20, 160);
			if (burst > left)
				burst = left;
			case ($urandom_range(2))
				0: alloc_pct = 92;
				1: alloc_pct = 50;
				default: alloc_pct = 12;
			endcase
			pool_mode = $urandom_range(2);
			// stretch without idle gaps or back-pressure in the middle of the run
			idle_en = !(left <= n / 2 && left > n / 2 - 350);
			repeat (burst) begin
				k = ($urandom_range(99) < alloc_pct) ? bbia_pkg::KIND_ALLOC : bbia_pkg::KIND_FREE;
				case (pool_mode)
					0: p = bbia_pkg::POOL_BLOCK;
					1: p = bbia_pkg::POOL_INODE;
					default: p = 1'($urandom_range(1));
				endcase
				count = (p == bbia_pkg::POOL_INODE) ? INODES : BLOCKS;
				if ($urandom_range(99) < 88)
					idx = 8'($urandom_range(count - 1));
				else
					idx = 8'($urandom_range(255, count));
				send_item(k, p, idx);
			end
			left -= burst;
		end
		idle_en = 1'b1;
	endtask

	initial begin
		pool_bits[bbia_pkg::POOL_BLOCK]      = '0;
		pool_bits[bbia_pkg::POOL_BLOCK][9:0] = '1;
		pool_bits[bbia_pkg::POOL_INODE]      = '0;
		pool_bits[bbia_pkg::POOL_INODE][0]   = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_layout();
		test_free_edges();
		test_random(RANDOM_ITEMS);

		req_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run covered %0d allocations (%0d with pool full)", n_alloc, n_full);
		$display("and %0d frees (%0d out of range); %0d mismatches over %0d cycles",
			n_free, n_range, n_err, cycles);
		if (n_err == 0 && pending_rsps.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
